### rtl/swsfr_pkg.sv
// swsfr_pkg: shared types and constants of the sliding window sender
// no dependencies; imported by every module of the block but swsfr_ram

package swsfr_pkg;

  // sequence numbers and register field widths
  localparam int SEQ_W     = 32;
  localparam int MODE_W    = 2;
  localparam int WS_W      = 4;
  localparam int TRIG_W    = 3;
  localparam int DUP_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;

  // remainder unit: reciprocal multiply, then multiply back and subtract
  localparam int MOD_CYCLES = 2;
  localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

  // request modes
  localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUP_TRIGGER = 1'd1;

  // reset values and limits
  localparam logic [WS_W-1:0]   WS_RESET   = 4'd4;
  localparam logic [TRIG_W-1:0] TRIG_RESET = 3'd4;
  localparam logic [TRIG_W-1:0] TRIG_MIN   = 3'd2;
  localparam logic [DUP_W-1:0]  DUP_MAX    = 3'd7;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request fields, start remainder unit
    logic exec;     // update state, access packet buffer, load result
  } swsfr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic mod_last; // remainder unit is in its final cycle
  } swsfr_stat_t;

endpackage

### rtl/sliding_window_sender_fast_retransmit.sv
// sliding_window_sender_fast_retransmit: top level of the windowed sender
// uses swsfr_pkg, swsfr_ctrl and swsfr_dp
//
//  channel   ports                              handshake
//  --------  ---------------------------------  ---------------------------
//  request   in_mode .. in_expired_seq          start & !busy
//  result    out_accepted .. out_window_full    out_valid, one cycle
//  config    cfg_index, cfg_data                cfg_valid & cfg_ready
//
// each request passes from acceptance through the remainder unit, which maps the
// 32-bit sequence number to a buffer slot (reciprocal multiply, then multiply
// back and subtract), then an execute step that updates state and accesses the
// buffer, then the registered buffer read, to its result strobe; the next request
// can be taken in the cycle the result is shown, so a request is taken only once
// the last one's result is shown. reset is synchronous and active low; results
// cannot be stalled, cfg_ready is always high

module sliding_window_sender_fast_retransmit
  import swsfr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    start,
  output logic                    busy,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  input  logic [SEQ_W-1:0]        in_ack_number,
  input  logic                    in_ack_checksum_ok,
  input  logic [SEQ_W-1:0]        in_expired_seq,
  // result channel
  output logic                    out_valid,
  output logic                    out_accepted,
  output logic                    out_tx_valid,
  output logic [SEQ_W-1:0]        out_tx_seq,
  output logic [PAYLOAD_BITS-1:0] out_tx_payload,
  output logic                    out_timer_stop,
  output logic [SEQ_W-1:0]        out_stop_seq,
  output logic                    out_timer_start,
  output logic [SEQ_W-1:0]        out_start_seq,
  output logic                    out_window_full,
  // configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data
);

  swsfr_cmd_t  cmd;
  swsfr_stat_t st;

  assign cfg_ready = 1'b1;

  swsfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .st        (st)
  );

  swsfr_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_mode            (in_mode),
    .in_payload         (in_payload),
    .in_ack_number      (in_ack_number),
    .in_ack_checksum_ok (in_ack_checksum_ok),
    .in_expired_seq     (in_expired_seq),
    .out_accepted       (out_accepted),
    .out_tx_valid       (out_tx_valid),
    .out_tx_seq         (out_tx_seq),
    .out_tx_payload     (out_tx_payload),
    .out_timer_stop     (out_timer_stop),
    .out_stop_seq       (out_stop_seq),
    .out_timer_start    (out_timer_start),
    .out_start_seq      (out_start_seq),
    .out_window_full    (out_window_full)
  );

endmodule

### rtl/swsfr_ram.sv
// swsfr_ram: generic single write, single read port ram with registered read
// no dependencies

module swsfr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/swsfr_mod.sv
// swsfr_mod: remainder of a sequence number by the buffer depth
// uses swsfr_pkg; reciprocal multiply, then multiply back

module swsfr_mod
  import swsfr_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic [SEQ_W-1:0]         value,
  output logic                     last,
  output logic [$clog2(DEPTH)-1:0] rem
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = 2 * SEQ_W + 1;
  // ceil(2^(SEQ_W+AW) / DEPTH) gives the exact quotient of every sequence number
  localparam logic [SEQ_W:0] MAGIC =
    (SEQ_W+1)'(((64'd1 << (SEQ_W + AW)) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

  logic [SEQ_W-1:0]     x_r, x_nxt;
  logic [SEQ_W-1:0]     q_r, q_nxt;
  logic [AW-1:0]        rem_r, rem_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic [PW-1:0]        prod;
  logic [SEQ_W-1:0]     back;

  // quotient estimate and what is left after taking it back out
  assign prod = {{(SEQ_W+1){1'b0}}, x_r} * {{SEQ_W{1'b0}}, MAGIC};
  assign back = x_r - SEQ_W'(q_r * SEQ_W'(DEPTH));

  // the quotient is formed first, then the remainder from it
  always_comb begin
    x_nxt   = x_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (load) begin
      x_nxt   = value;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (cnt_r == '0) begin
        q_nxt = SEQ_W'(prod >> (SEQ_W + AW));
      end else begin
        rem_nxt = back[AW-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MOD_CNT_W'(MOD_CYCLES - 1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
      rem_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    q_r <= q_nxt;
  end

  assign last = run_r && (cnt_r == MOD_CNT_W'(MOD_CYCLES - 1));
  assign rem  = rem_r;

`ifndef SYNTH
  // the stored remainder never reaches the depth
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> ({1'b0, rem_r} < (AW+1)'(DEPTH)))
    else $error("remainder out of range");

  // the quotient estimate is exact
  a_quot_exact: assert property (@(posedge clk) disable iff (!rst_n)
    last |-> (back < SEQ_W'(DEPTH)))
    else $error("quotient estimate off");
`endif

endmodule

### rtl/swsfr_dp.sv
// swsfr_dp: window state, configuration, packet buffer and result registers
// uses swsfr_pkg, swsfr_mod and swsfr_ram

module swsfr_dp
  import swsfr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  swsfr_cmd_t              cmd,
  output swsfr_stat_t             st,
  // configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data,
  // request fields
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  input  logic [SEQ_W-1:0]        in_ack_number,
  input  logic                    in_ack_checksum_ok,
  input  logic [SEQ_W-1:0]        in_expired_seq,
  // result fields
  output logic                    out_accepted,
  output logic                    out_tx_valid,
  output logic [SEQ_W-1:0]        out_tx_seq,
  output logic [PAYLOAD_BITS-1:0] out_tx_payload,
  output logic                    out_timer_stop,
  output logic [SEQ_W-1:0]        out_stop_seq,
  output logic                    out_timer_start,
  output logic [SEQ_W-1:0]        out_start_seq,
  output logic                    out_window_full
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  // configuration
  logic [WS_W-1:0]   ws_r;
  logic [TRIG_W-1:0] trig_r;

  // window state
  logic [SEQ_W-1:0] base_r, base_nxt;
  logic [SEQ_W-1:0] next_r, next_nxt;
  logic             waiting_r, waiting_nxt;
  logic [SEQ_W-1:0] last_r, last_nxt;
  logic [DUP_W-1:0] dup_r, dup_nxt;

  // latched request
  logic [MODE_W-1:0]       mode_r;
  logic [PAYLOAD_BITS-1:0] payload_r;
  logic [SEQ_W-1:0]        ack_r;
  logic                    ck_r;
  logic [SEQ_W-1:0]        exp_r;

  // result registers
  logic                    acc_r, acc_nxt;
  logic                    txv_r, txv_nxt;
  logic [SEQ_W-1:0]        txseq_r, txseq_nxt;
  logic [PAYLOAD_BITS-1:0] txpay_r, txpay_nxt;
  logic                    resend_r, resend_nxt;
  logic                    tstop_r, tstop_nxt;
  logic [SEQ_W-1:0]        stopseq_r, stopseq_nxt;
  logic                    tstart_r, tstart_nxt;
  logic [SEQ_W-1:0]        startseq_r, startseq_nxt;
  logic                    full_r;

  // slot arithmetic and buffer
  logic [SEQ_W-1:0]        mod_value;
  logic [AW-1:0]           slot;
  logic                    ram_we;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  // decisions
  logic [SEQ_W:0]   limit;
  logic             room;
  logic [SEQ_W-1:0] next_inc;
  logic [SEQ_W-1:0] ack_inc;
  logic             good_ack;
  logic             fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= WS_RESET;
      trig_r <= TRIG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SIZE: ws_r   <= cfg_data[WS_W-1:0];
        REG_DUP_TRIGGER: trig_r <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // sequence number whose slot this request needs
  always_comb begin
    case (in_mode)
      MODE_SEND:    mod_value = next_r;
      MODE_ACK:     mod_value = base_r;
      MODE_TIMEOUT: mod_value = in_expired_seq;
      default:      mod_value = '0;
    endcase
  end

  swsfr_mod #(.DEPTH(BUFFER_DEPTH)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cmd.capture),
    .value (mod_value),
    .last  (st.mod_last),
    .rem   (slot)
  );

  swsfr_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(BUFFER_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (payload_r),
    .re    (cmd.exec),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // latch the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r    <= in_mode;
      payload_r <= in_payload;
      ack_r     <= in_ack_number;
      ck_r      <= in_ack_checksum_ok;
      exp_r     <= in_expired_seq;
    end
  end

  // compares and increments used by the per mode update
  assign limit    = {1'b0, base_r} + (SEQ_W+1)'(ws_r);
  assign room     = {1'b0, next_r} < limit;
  assign next_inc = next_r + 1'b1;
  assign ack_inc  = ack_r + 1'b1;
  assign good_ack = ck_r && (ack_r >= base_r);
  assign fire     = (dup_r != DUP_MAX) && ((dup_r + 1'b1) == trig_r) && (trig_r >= TRIG_MIN);

  // per mode state update and result
  always_comb begin
    base_nxt     = base_r;
    next_nxt     = next_r;
    waiting_nxt  = waiting_r;
    last_nxt     = last_r;
    dup_nxt      = dup_r;
    acc_nxt      = 1'b0;
    txv_nxt      = 1'b0;
    txseq_nxt    = '0;
    txpay_nxt    = '0;
    resend_nxt   = 1'b0;
    tstop_nxt    = 1'b0;
    stopseq_nxt  = '0;
    tstart_nxt   = 1'b0;
    startseq_nxt = '0;
    ram_we       = 1'b0;
    case (mode_r)
      MODE_SEND: begin
        if (!waiting_r) begin
          acc_nxt = 1'b1;
          if (room) begin
            ram_we    = cmd.exec;
            txv_nxt   = 1'b1;
            txseq_nxt = next_r;
            txpay_nxt = payload_r;
            if (base_r == next_r) begin
              tstart_nxt   = 1'b1;
              startseq_nxt = next_r;
            end
            next_nxt = next_inc;
            if ({1'b0, next_inc} == limit) begin
              waiting_nxt = 1'b1;
            end
          end
        end
      end
      MODE_ACK: begin
        if (good_ack) begin
          base_nxt    = ack_inc;
          tstop_nxt   = 1'b1;
          stopseq_nxt = base_r;
          if (ack_inc != next_r) begin
            tstart_nxt   = 1'b1;
            startseq_nxt = ack_inc;
          end
          waiting_nxt = 1'b0;
        end else if (ack_r == last_r) begin
          // duplicate: count, fast retransmit of the base packet
          if (dup_r != DUP_MAX) begin
            dup_nxt = dup_r + 1'b1;
          end
          if (fire) begin
            tstop_nxt    = 1'b1;
            stopseq_nxt  = ack_inc;
            tstart_nxt   = 1'b1;
            startseq_nxt = ack_inc;
            txv_nxt      = 1'b1;
            txseq_nxt    = base_r;
            resend_nxt   = 1'b1;
          end
        end else begin
          last_nxt = ack_r;
          dup_nxt  = DUP_W'(1);
        end
      end
      MODE_TIMEOUT: begin
        tstop_nxt    = 1'b1;
        stopseq_nxt  = exp_r;
        tstart_nxt   = 1'b1;
        startseq_nxt = exp_r;
        txv_nxt      = 1'b1;
        txseq_nxt    = exp_r;
        resend_nxt   = 1'b1;
      end
      default: ;
    endcase
  end

  // window state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      next_r    <= '0;
      waiting_r <= 1'b0;
      last_r    <= '0;
      dup_r     <= '0;
    end else if (cmd.exec) begin
      base_r    <= base_nxt;
      next_r    <= next_nxt;
      waiting_r <= waiting_nxt;
      last_r    <= last_nxt;
      dup_r     <= dup_nxt;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc_r      <= acc_nxt;
      txv_r      <= txv_nxt;
      txseq_r    <= txseq_nxt;
      txpay_r    <= txpay_nxt;
      resend_r   <= resend_nxt;
      tstop_r    <= tstop_nxt;
      stopseq_r  <= stopseq_nxt;
      tstart_r   <= tstart_nxt;
      startseq_r <= startseq_nxt;
      full_r     <= waiting_nxt;
    end
  end

  assign out_accepted    = acc_r;
  assign out_tx_valid    = txv_r;
  assign out_tx_seq      = txseq_r;
  assign out_tx_payload  = resend_r ? ram_rdata : txpay_r;
  assign out_timer_stop  = tstop_r;
  assign out_stop_seq    = stopseq_r;
  assign out_timer_start = tstart_r;
  assign out_start_seq   = startseq_r;
  assign out_window_full = full_r;

`ifndef SYNTH
  // a good acknowledgement always reopens the window
  a_ack_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && mode_r == MODE_ACK && good_ack) |=> !waiting_r)
    else $error("good ack left sender waiting");

  // a refused send never advances the sequence counter
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && mode_r == MODE_SEND && waiting_r) |=> (next_r == $past(next_r)))
    else $error("refused send moved next_seq");
`endif

endmodule

### rtl/swsfr_ctrl.sv
// swsfr_ctrl: request sequencing for the sliding window sender
// uses swsfr_pkg; drives the datapath commands and the result strobe

module swsfr_ctrl
  import swsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  output logic        out_valid,
  output swsfr_cmd_t  cmd,
  input  swsfr_stat_t st
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MODW = 4'b0010,
    S_EXEC = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  // a request may enter while idle or while the last result is shown
  assign busy = !((state_r == S_IDLE) || (state_r == S_DONE));
  assign take = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take) state_nxt = S_MODW;
      end
      S_MODW: begin
        if (st.mod_last) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = take ? S_MODW : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  assign cmd.capture = take;
  assign cmd.exec    = (state_r == S_EXEC);
  assign out_valid   = (state_r == S_DONE);

`ifndef SYNTH
  // every accepted request yields its result strobe once the remainder and execute states are through
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##4 out_valid)
    else $error("result not delivered on time");

  // results never come in adjacent cycles
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");
`endif

endmodule
